// ===== rtl/tpg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_pkg
// shared types, register codes, constants and helper functions of the
// trajectory position generator
// ----------------------------------------------------------------------------
package tpg_pkg;

    localparam int TIME_W     = 64;
    localparam int PERIOD_W   = 48;
    localparam int COORD_W    = 32;
    localparam int LEN_W      = 30;
    localparam int SEG_ANG_W  = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int TURN_W     = 32;
    localparam int CORDIC_W   = 34;
    localparam int TRIG_W     = 32;
    localparam int MAG_W      = LEN_W + 1;
    localparam int SUM_W      = COORD_W + 3;

    localparam logic [MODE_W-1:0] SHAPE_POINT  = 2'd0;
    localparam logic [MODE_W-1:0] SHAPE_CIRCLE = 2'd1;
    localparam logic [MODE_W-1:0] SHAPE_LINE   = 2'd2;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [CORDIC_W-1:0] NEG_ONE_Q30 = -34'sd1073741824;
    localparam logic signed [2*COORD_W-1:0] HALF_Q30   = 64'sd536870912;

    typedef enum logic [1:0] {
        KIND_POINT  = 2'b00,
        KIND_CIRCLE = 2'b01,
        KIND_LINE   = 2'b10
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHAPE_MODE     = 3'd0,
        REG_REVERSE        = 3'd1,
        REG_OFFSET_X       = 3'd2,
        REG_OFFSET_Y       = 3'd3,
        REG_CIRCLE_RADIUS  = 3'd4,
        REG_SEGMENT_LENGTH = 3'd5,
        REG_SEGMENT_ANGLE  = 3'd6,
        REG_PERIOD_SAMPLES = 3'd7
    } cfg_addr_t;

    typedef struct packed {
        logic [MODE_W-1:0]         shape_mode;
        logic                      reverse;
        logic signed [COORD_W-1:0] offset_x;
        logic signed [COORD_W-1:0] offset_y;
        logic [LEN_W-1:0]          circle_radius;
        logic [LEN_W-1:0]          segment_length;
        logic [SEG_ANG_W-1:0]      segment_angle;
        logic [PERIOD_W-1:0]       period_samples;
    } tpg_cfg_t;

    // arctangent of 2^-i in turns, 2^32 per turn
    function automatic logic [TURN_W-1:0] atan_turn(input int idx);
        logic [TURN_W-1:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] c;
        if (v > ONE_Q30)
        begin
            c = ONE_Q30;
        end
        else if (v < NEG_ONE_Q30)
        begin
            c = NEG_ONE_Q30;
        end
        else
        begin
            c = v;
        end
        return c[TRIG_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic [COORD_W-1:0] r;
        if ((v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1))
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/tpg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_front
// classifies each time stamp by shape and works out its phase with a
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tpg_front #(
    parameter int PHASE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tpg_pkg::tpg_cfg_t           cfg,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tpg_pkg::TIME_W-1:0]  s_tdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [PHASE_BITS-1:0]       out_phase,
    output tpg_pkg::kind_t              out_kind
);
    import tpg_pkg::*;

    localparam int STEPS = TIME_W + PHASE_BITS;

    logic [PERIOD_W-1:0]   period_eff;
    logic                  adv;
    kind_t                 kind_in;
    logic [STEPS-1:0]      vld_reg;
    logic [STEPS-1:0]      vld_next;
    logic [PERIOD_W-1:0]   rem_reg [STEPS];
    logic [TIME_W-1:0]     num_reg [STEPS];
    logic [PHASE_BITS-1:0] quo_reg [STEPS];
    kind_t                 kind_reg [STEPS];

    // zero period acts as one
    assign period_eff = (cfg.period_samples == '0) ? PERIOD_W'(1) : cfg.period_samples;

    always_comb
    begin
        case (cfg.shape_mode)
            SHAPE_CIRCLE: kind_in = KIND_CIRCLE;
            SHAPE_LINE:   kind_in = KIND_LINE;
            default:      kind_in = KIND_POINT;
        endcase
    end

    assign adv      = !vld_reg[STEPS-1] || out_ready;
    assign vld_next = {vld_reg[STEPS-2:0], s_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [PERIOD_W-1:0]   rem_in;
        logic [TIME_W-1:0]     num_in;
        logic [PHASE_BITS-1:0] quo_in;
        kind_t                 kd_in;
        logic [PERIOD_W:0]     trial;
        logic [PERIOD_W+1:0]   diff;
        logic                  ge;
        logic [PERIOD_W-1:0]   rem_next;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = s_tdata;
            assign quo_in = '0;
            assign kd_in  = kind_in;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign kd_in  = kind_reg[k-1];
        end

        assign trial    = {rem_in, num_in[TIME_W-1]};
        assign diff     = {1'b0, trial} - {2'b00, period_eff};
        assign ge       = !diff[PERIOD_W+1];
        assign rem_next = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= {num_in[TIME_W-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[PHASE_BITS-2:0], ge};
                kind_reg[k] <= kd_in;
            end
        end
    end

    assign s_tready  = adv;
    assign out_valid = vld_reg[STEPS-1];
    assign out_phase = quo_reg[STEPS-1];
    assign out_kind  = kind_reg[STEPS-1];

endmodule

// ===== rtl/tpg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_queue
// small first-in first-out queue between the phase front and the
// geometry back end
// ----------------------------------------------------------------------------
module tpg_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/tpg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_back
// turns a phase into a position: line distance, pipelined cordic,
// quadrant fix, scaling, reverse, offset and saturation
// ----------------------------------------------------------------------------
module tpg_back #(
    parameter int PHASE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpg_pkg::tpg_cfg_t             cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [PHASE_BITS-1:0]         in_phase,
    input  tpg_pkg::kind_t                in_kind,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [2*tpg_pkg::COORD_W-1:0] m_tdata
);
    import tpg_pkg::*;

    localparam int NS     = CORDIC_STAGES + 5;
    localparam int PROD_W = LEN_W + PHASE_BITS;
    localparam logic [PHASE_BITS-1:0] HALF_P = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam logic [PROD_W:0] ROUND_M = (PROD_W + 1)'(1) << (PHASE_BITS - 2);

    logic                        adv;
    logic [NS-1:0]               vld_reg;
    logic [NS-1:0]               vld_next;

    // entry stage
    logic [TURN_W-1:0]           ang;
    logic [PHASE_BITS-1:0]       pe;
    logic [PROD_W-1:0]           e_prod_reg;
    logic signed [CORDIC_W-1:0]  e_z_reg;
    logic [1:0]                  e_quad_reg;
    kind_t                       e_kind_reg;

    // rotation stages
    logic signed [CORDIC_W-1:0]  x_reg [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  y_reg [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  z_reg [CORDIC_STAGES];
    logic [1:0]                  quad_reg [CORDIC_STAGES];
    kind_t                       kind_reg [CORDIC_STAGES];
    logic [PROD_W-1:0]           prod_reg [CORDIC_STAGES];

    // quadrant stage
    logic signed [TRIG_W-1:0]    c_val;
    logic signed [TRIG_W-1:0]    s_val;
    logic signed [TRIG_W-1:0]    cs_next;
    logic signed [TRIG_W-1:0]    sn_next;
    logic [PROD_W:0]             dist_sum;
    logic [MAG_W-1:0]            mag_next;
    logic signed [TRIG_W-1:0]    q_cs_reg;
    logic signed [TRIG_W-1:0]    q_sn_reg;
    logic [MAG_W-1:0]            q_mag_reg;
    kind_t                       q_kind_reg;

    // multiply stage
    logic signed [2*COORD_W-1:0] m_px_reg;
    logic signed [2*COORD_W-1:0] m_py_reg;
    kind_t                       m_kind_reg;

    // round stage
    logic signed [2*COORD_W-1:0] rnd_x;
    logic signed [2*COORD_W-1:0] rnd_y;
    logic signed [CORDIC_W-1:0]  r_px_next;
    logic signed [CORDIC_W-1:0]  r_py_next;
    logic signed [CORDIC_W-1:0]  r_px_reg;
    logic signed [CORDIC_W-1:0]  r_py_reg;

    // offset and output stage
    logic signed [SUM_W-1:0]     sum_x;
    logic signed [SUM_W-1:0]     sum_y;
    logic [2*COORD_W-1:0]        out_reg;

    assign adv      = !vld_reg[NS-1] || m_tready;
    assign vld_next = {vld_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign ang = (in_kind == KIND_LINE) ? {cfg.segment_angle, {(TURN_W-SEG_ANG_W){1'b0}}}
                                        : {in_phase, {(TURN_W-PHASE_BITS){1'b0}}};
    // fold the second half of the period back toward the start
    assign pe  = (in_phase <= HALF_P) ? in_phase : (~in_phase + 1'b1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_prod_reg <= cfg.segment_length * pe;
            e_z_reg    <= {{(CORDIC_W-TURN_W+2){1'b0}}, ang[TURN_W-3:0]};
            e_quad_reg <= ang[TURN_W-1:TURN_W-2];
            e_kind_reg <= in_kind;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic signed [CORDIC_W-1:0] z_in;
        logic [1:0]                 qd_in;
        kind_t                      kd_in;
        logic [PROD_W-1:0]          pr_in;
        logic signed [CORDIC_W-1:0] at;
        logic signed [CORDIC_W-1:0] x_sh;
        logic signed [CORDIC_W-1:0] y_sh;
        logic                       up;

        if (i == 0)
        begin : g_first
            assign x_in  = CORDIC_GAIN;
            assign y_in  = '0;
            assign z_in  = e_z_reg;
            assign qd_in = e_quad_reg;
            assign kd_in = e_kind_reg;
            assign pr_in = e_prod_reg;
        end
        else
        begin : g_rest
            assign x_in  = x_reg[i-1];
            assign y_in  = y_reg[i-1];
            assign z_in  = z_reg[i-1];
            assign qd_in = quad_reg[i-1];
            assign kd_in = kind_reg[i-1];
            assign pr_in = prod_reg[i-1];
        end

        assign at   = $signed({{(CORDIC_W-TURN_W){1'b0}}, atan_turn(i)});
        assign x_sh = x_in >>> i;
        assign y_sh = y_in >>> i;
        assign up   = !z_in[CORDIC_W-1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[i]    <= up ? (x_in - y_sh) : (x_in + y_sh);
                y_reg[i]    <= up ? (y_in + x_sh) : (y_in - x_sh);
                z_reg[i]    <= up ? (z_in - at) : (z_in + at);
                quad_reg[i] <= qd_in;
                kind_reg[i] <= kd_in;
                prod_reg[i] <= pr_in;
            end
        end
    end

    assign c_val = clamp_q30(x_reg[CORDIC_STAGES-1]);
    assign s_val = clamp_q30(y_reg[CORDIC_STAGES-1]);

    always_comb
    begin
        case (quad_reg[CORDIC_STAGES-1])
            2'd0:
            begin
                cs_next = c_val;
                sn_next = s_val;
            end
            2'd1:
            begin
                cs_next = -s_val;
                sn_next = c_val;
            end
            2'd2:
            begin
                cs_next = -c_val;
                sn_next = -s_val;
            end
            default:
            begin
                cs_next = s_val;
                sn_next = -c_val;
            end
        endcase
    end

    assign dist_sum = {1'b0, prod_reg[CORDIC_STAGES-1]} + ROUND_M;
    assign mag_next = (kind_reg[CORDIC_STAGES-1] == KIND_LINE)
                    ? dist_sum[PHASE_BITS-1 +: MAG_W]
                    : {1'b0, cfg.circle_radius};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_cs_reg   <= cs_next;
            q_sn_reg   <= sn_next;
            q_mag_reg  <= mag_next;
            q_kind_reg <= kind_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_px_reg   <= $signed({1'b0, q_mag_reg}) * q_cs_reg;
            m_py_reg   <= $signed({1'b0, q_mag_reg}) * q_sn_reg;
            m_kind_reg <= q_kind_reg;
        end
    end

    assign rnd_x = m_px_reg + HALF_Q30;
    assign rnd_y = m_py_reg + HALF_Q30;

    always_comb
    begin
        r_px_next = rnd_x[2*COORD_W-1 -: CORDIC_W];
        r_py_next = rnd_y[2*COORD_W-1 -: CORDIC_W];
        if (m_kind_reg == KIND_POINT)
        begin
            r_px_next = '0;
            r_py_next = '0;
        end
        else if (cfg.reverse)
        begin
            r_px_next = -r_px_next;
            r_py_next = -r_py_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_px_reg <= r_px_next;
            r_py_reg <= r_py_next;
        end
    end

    assign sum_x = {r_px_reg[CORDIC_W-1], r_px_reg}
                 + {{(SUM_W-COORD_W){cfg.offset_x[COORD_W-1]}}, cfg.offset_x};
    assign sum_y = {r_py_reg[CORDIC_W-1], r_py_reg}
                 + {{(SUM_W-COORD_W){cfg.offset_y[COORD_W-1]}}, cfg.offset_y};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= {sat_coord(sum_y), sat_coord(sum_x)};
        end
    end

    assign in_ready = adv;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = out_reg;

endmodule

// ===== rtl/trajectory_position_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_position_generator_core
// sample time stamp in, 2-d node position on a periodic trajectory out
//
//  channel  dir  width  contents
//  s_*      in   64     sample_time
//  m_*      out  64     pos_x [31:0], pos_y [63:32]
//  cfg_*    in   48     register writes, index 0..7
//
// one time stamp per cycle sustained while m_tready is high; each stamp
// passes 64 + PHASE_BITS divider stages, the queue, then CORDIC_STAGES + 5
// geometry stages; the divider is the longest, one quotient bit per stage
// reset clears valid bits, queue pointers and config only; no clearing pass
// m_tready low stalls the back end; the queue holds QUEUE_DEPTH items
// before the front end and s_tready stall too
// ----------------------------------------------------------------------------
module trajectory_position_generator_core #(
    parameter int PHASE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tpg_pkg::TIME_W-1:0]      s_tdata,   // sample_time
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*tpg_pkg::COORD_W-1:0]   m_tdata,   // pos_x, pos_y
    input  logic                            cfg_we,
    input  logic [tpg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tpg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tpg_pkg::*;

    localparam int QW = PHASE_BITS + 2;

    tpg_cfg_t              cfg_reg;
    logic                  f_valid;
    logic                  f_ready;
    logic [PHASE_BITS-1:0] f_phase;
    kind_t                 f_kind;
    logic                  b_valid;
    logic                  b_ready;
    logic [QW-1:0]         b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape_mode     <= SHAPE_POINT;
            cfg_reg.reverse        <= 1'b0;
            cfg_reg.offset_x       <= '0;
            cfg_reg.offset_y       <= '0;
            cfg_reg.circle_radius  <= LEN_W'(65536);
            cfg_reg.segment_length <= LEN_W'(65536);
            cfg_reg.segment_angle  <= '0;
            cfg_reg.period_samples <= PERIOD_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SHAPE_MODE:     cfg_reg.shape_mode     <= cfg_wdata[MODE_W-1:0];
                REG_REVERSE:        cfg_reg.reverse        <= cfg_wdata[0];
                REG_OFFSET_X:       cfg_reg.offset_x       <= cfg_wdata[COORD_W-1:0];
                REG_OFFSET_Y:       cfg_reg.offset_y       <= cfg_wdata[COORD_W-1:0];
                REG_CIRCLE_RADIUS:  cfg_reg.circle_radius  <= cfg_wdata[LEN_W-1:0];
                REG_SEGMENT_LENGTH: cfg_reg.segment_length <= cfg_wdata[LEN_W-1:0];
                REG_SEGMENT_ANGLE:  cfg_reg.segment_angle  <= cfg_wdata[SEG_ANG_W-1:0];
                REG_PERIOD_SAMPLES: cfg_reg.period_samples <= cfg_wdata[PERIOD_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    tpg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_phase (f_phase),
        .out_kind  (f_kind)
    );

    tpg_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_kind, f_phase}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    tpg_back #(
        .PHASE_BITS    (PHASE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (b_valid),
        .in_ready (b_ready),
        .in_phase (b_data[PHASE_BITS-1:0]),
        .in_kind  (kind_t'(b_data[QW-1:PHASE_BITS])),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/tpg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpg_checker
// port-level checks of the trajectory position generator: results only
// for accepted stamps, bounded occupancy, quiet reset, held output
// ----------------------------------------------------------------------------
module tpg_checker #(
    parameter int PHASE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [2*tpg_pkg::COORD_W-1:0] m_tdata
);
    import tpg_pkg::*;

    localparam int CAP   = TIME_W + PHASE_BITS + QUEUE_DEPTH + CORDIC_STAGES + 5;
    localparam int CNT_W = $clog2(CAP + 2);

    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb
    begin
        held_next = held_reg;
        if (in_xfer && !out_xfer)
        begin
            held_next = held_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            held_next = held_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    a_quiet_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (held_reg != '0))
        else $error("result without an accepted stamp");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAP))
        else $error("more stamps in flight than pipeline capacity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind trajectory_position_generator_core tpg_checker #(
    .PHASE_BITS    (PHASE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
) u_tpg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
